FILE: sv/scfr_pkg.sv
// ----------------------------------------------------------------------------
// scfr_pkg
// Shared types, constants and the CRC-8 byte update for the status frame
// receiver.
// ----------------------------------------------------------------------------
package scfr_pkg;

    localparam logic [7:0] START_FIRST  = 8'hA5;
    localparam logic [7:0] START_SECOND = 8'h5A;
    localparam logic [7:0] TYPE_STATUS  = 8'h53;
    localparam logic [7:0] CRC_POLY     = 8'h07;
    localparam int         CRC_TOP      = 7;

    typedef enum logic [1:0] {
        FS_OK        = 2'd0,
        FS_BAD_TYPE  = 2'd1,
        FS_CRC_ERR   = 2'd2,
        FS_BAD_START = 2'd3
    } t_frame_status;

    typedef struct packed {
        t_frame_status      status;
        logic [7:0]         seq;
        logic signed [31:0] ticks;
        logic signed [15:0] vel;
        logic [7:0]         rx_crc;
        logic [7:0]         calc_crc;
    } t_frame_result;

    // CRC-8/SMBUS, MSB first, one byte
    function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                               input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            if (c[CRC_TOP]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: sv/scfr_if.sv
// ----------------------------------------------------------------------------
// scfr_if
// Valid/ready channels of the status frame receiver: the received byte
// stream and the frame result stream.
// ----------------------------------------------------------------------------
interface scfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scfr_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         frame_status;
    logic [7:0]         sequence_res;
    logic signed [31:0] encoder_ticks;
    logic signed [15:0] velocity_mrad;
    logic [7:0]         received_crc;
    logic [7:0]         computed_crc;

    modport source (output valid, output frame_status, output sequence_res,
                    output encoder_ticks, output velocity_mrad,
                    output received_crc, output computed_crc, input ready);
    modport sink   (input valid, input frame_status, input sequence_res,
                    input encoder_ticks, input velocity_mrad,
                    input received_crc, input computed_crc, output ready);
endinterface

FILE: sv/scfr_deframer.sv
// ----------------------------------------------------------------------------
// scfr_deframer
// Frame sync state machine, field capture and running CRC. Produces at most
// one result per accepted byte, combinationally, for the result register.
// ----------------------------------------------------------------------------
module scfr_deframer
    import scfr_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [7:0]    i_byte,
    output logic          o_res_valid,
    output t_frame_result o_res
);

    typedef enum logic [3:0] {
        ST_HUNT  = 4'd0,
        ST_SYNC  = 4'd1,
        ST_TYPE  = 4'd2,
        ST_SEQ   = 4'd3,
        ST_TICK0 = 4'd4,
        ST_TICK1 = 4'd5,
        ST_TICK2 = 4'd6,
        ST_TICK3 = 4'd7,
        ST_VEL0  = 4'd8,
        ST_VEL1  = 4'd9,
        ST_CRC   = 4'd10
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_crc, n_crc;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_seq, n_seq;
    logic [31:0] r_ticks, n_ticks;
    logic [15:0] r_vel, n_vel;
    logic [7:0]  crc_next;

    assign crc_next = crc8_update(r_crc, i_byte);

    always_comb begin
        n_phase     = r_phase;
        n_crc       = r_crc;
        n_type      = r_type;
        n_seq       = r_seq;
        n_ticks     = r_ticks;
        n_vel       = r_vel;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_en) begin
            unique case (r_phase)
                ST_SYNC: begin
                    if (i_byte == START_SECOND) begin
                        n_phase = ST_TYPE;
                        n_crc   = '0;
                    end else begin
                        // bad second start: byte consumed, fields stay zero
                        n_phase     = ST_HUNT;
                        o_res_valid = 1'b1;
                        o_res.status = FS_BAD_START;
                    end
                end
                ST_TYPE, ST_SEQ, ST_TICK0, ST_TICK1, ST_TICK2, ST_TICK3,
                ST_VEL0, ST_VEL1: begin
                    n_crc   = crc_next;
                    n_phase = t_phase'(r_phase + 4'd1);
                    if (r_phase == ST_TYPE) begin
                        n_type = i_byte;
                    end else if (r_phase == ST_SEQ) begin
                        n_seq = i_byte;
                    end else if (r_phase == ST_VEL0 || r_phase == ST_VEL1) begin
                        n_vel = {i_byte, r_vel[15:8]};
                    end else begin
                        n_ticks = {i_byte, r_ticks[31:8]};
                    end
                end
                ST_CRC: begin
                    n_phase     = ST_HUNT;
                    o_res_valid = 1'b1;
                    if (r_type != TYPE_STATUS) begin
                        o_res.status = FS_BAD_TYPE;
                    end else if (i_byte != r_crc) begin
                        o_res.status = FS_CRC_ERR;
                    end else begin
                        o_res.status = FS_OK;
                    end
                    o_res.seq      = r_seq;
                    o_res.ticks    = $signed(r_ticks);
                    o_res.vel      = $signed(r_vel);
                    o_res.rx_crc   = i_byte;
                    o_res.calc_crc = r_crc;
                end
                default: begin
                    // hunting, and any unused code acts as hunting
                    n_phase = (i_byte == START_FIRST) ? ST_SYNC : ST_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ST_HUNT;
            r_crc   <= '0;
            r_type  <= '0;
            r_seq   <= '0;
            r_ticks <= '0;
            r_vel   <= '0;
        end else begin
            r_phase <= n_phase;
            r_crc   <= n_crc;
            r_type  <= n_type;
            r_seq   <= n_seq;
            r_ticks <= n_ticks;
            r_vel   <= n_vel;
        end
    end

endmodule

FILE: sv/scfr_out_reg.sv
// ----------------------------------------------------------------------------
// scfr_out_reg
// Result register with valid/ready handshake. Loads a new result in the
// same cycle the held one is taken.
// ----------------------------------------------------------------------------
module scfr_out_reg
    import scfr_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  t_frame_result i_data,
    input  logic          i_ready,
    output logic          o_free,
    output logic          o_valid,
    output t_frame_result o_data
);

    logic          r_valid;
    t_frame_result r_data;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

endmodule

FILE: sv/status_frame_receiver_crc8.sv
// ----------------------------------------------------------------------------
// status_frame_receiver_crc8
// Status frame receiver: syncs on A5 5A, captures type, sequence, encoder
// count and velocity, checks CRC-8/SMBUS and reports one result per frame and per bad start.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                  | handshake
//  i_rx     | in  | rx_byte                                  | valid/ready
//  o_res    | out | frame_status, sequence_res,              | valid/ready
//           |     | encoder_ticks, velocity_mrad,            |
//           |     | received_crc, computed_crc               |
//
//  One word per cycle while the input is not stalled. A byte is processed in the cycle it is accepted; its
//  result, if any, is on o_res from the next cycle.
//  Synchronous active-low reset returns to hunting with cleared state.
//  Input stalls only while a result is held and o_res.ready is low.
// ----------------------------------------------------------------------------
module status_frame_receiver_crc8
    import scfr_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    scfr_byte_if.sink     i_rx,
    scfr_result_if.source o_res
);

    logic          acc;
    logic          free;
    logic          res_valid;
    t_frame_result res_data;
    logic          out_valid;
    t_frame_result out_data;

    assign i_rx.ready = free;
    assign acc        = i_rx.valid && free;

    scfr_deframer u_deframer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (acc),
        .i_byte      (i_rx.rx_byte),
        .o_res_valid (res_valid),
        .o_res       (res_data)
    );

    scfr_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_data  (res_data),
        .i_ready (o_res.ready),
        .o_free  (free),
        .o_valid (out_valid),
        .o_data  (out_data)
    );

    assign o_res.valid         = out_valid;
    assign o_res.frame_status  = out_data.status;
    assign o_res.sequence_res  = out_data.seq;
    assign o_res.encoder_ticks = out_data.ticks;
    assign o_res.velocity_mrad = out_data.vel;
    assign o_res.received_crc  = out_data.rx_crc;
    assign o_res.computed_crc  = out_data.calc_crc;

    // a fresh result only follows an accepted word
    a_res_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(i_rx.valid && i_rx.ready))
        else $error("result without accepted word");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rx.ready |-> (o_res.valid && !o_res.ready))
        else $error("input stalled with free result register");

    a_ok_crc_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.frame_status == FS_OK) |->
            (o_res.received_crc == o_res.computed_crc))
        else $error("ok status with crc mismatch");

    a_bad_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.frame_status == FS_BAD_START) |->
            (o_res.sequence_res == '0 && o_res.encoder_ticks == '0 &&
             o_res.velocity_mrad == '0 && o_res.received_crc == '0 &&
             o_res.computed_crc == '0))
        else $error("bad start result carries fields");

endmodule
